// File: hdl/bicycle_pose_update_defines.svh
// Assertion macros shared by the pose update RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef BICYCLE_POSE_UPDATE_DEFINES_SVH
`define BICYCLE_POSE_UPDATE_DEFINES_SVH
`ifndef SYNTH
`define BPU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPU_ASSERT_IMPL(lbl, ante, cons, msg)
`define BPU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/bpu_pkg.sv
// Shared constants, widths and the CORDIC arctangent table for the pose update.
// No dependencies.
package bpu_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  // CORDIC angle (Q32), vector (Q30) and divisor widths
  localparam int ZW = 36;
  localparam int XW = 34;
  localparam int DW = 34;

  localparam longint PI_Q32      = 64'sd13493037705;
  localparam longint HALF_PI_Q32 = 64'sd6746518852;
  localparam longint UNIT30      = 64'sd1073741824;
  localparam longint GAIN30      = 64'sd652032874;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd3;

  // atan(2^-i) in Q32
  function automatic logic signed [ZW-1:0] atan_q32(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = 36'sd3373259426;
      5'd1:  r = 36'sd1991351318;
      5'd2:  r = 36'sd1052175346;
      5'd3:  r = 36'sd534100635;
      5'd4:  r = 36'sh00FFAADDC;
      5'd5:  r = 36'sh007FF556F;
      5'd6:  r = 36'sh003FFEAAB;
      5'd7:  r = 36'sh001FFFD55;
      5'd8:  r = 36'sh000FFFFAB;
      5'd9:  r = 36'sh0007FFFF5;
      5'd10: r = 36'sh0003FFFFF;
      5'd11: r = 36'sh000200000;
      5'd12: r = 36'sh000100000;
      5'd13: r = 36'sh000080000;
      5'd14: r = 36'sh000040000;
      5'd15: r = 36'sh000020000;
      5'd16: r = 36'sh000010000;
      5'd17: r = 36'sh000008000;
      5'd18: r = 36'sh000004000;
      5'd19: r = 36'sh000002000;
      5'd20: r = 36'sh000001000;
      5'd21: r = 36'sh000000800;
      5'd22: r = 36'sh000000400;
      5'd23: r = 36'sh000000200;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/bpu_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on bpu_pkg for widths, pi constants and the arctangent table.
module bpu_cordic import bpu_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [ZW-1:0] angle_i,
  input  logic signed [XW-1:0] seed_i,
  output logic                 done_o,
  output logic signed [XW-1:0] cos_o,
  output logic signed [XW-1:0] sin_o
);

  localparam int CW = $clog2(STEPS + 1);
  localparam logic signed [ZW-1:0] PI_Z   = ZW'(PI_Q32);
  localparam logic signed [ZW-1:0] HALF_Z = ZW'(HALF_PI_Q32);

  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic                 neg_q, busy_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] at;

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = atan_q32(5'(cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      neg_q  <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= seed_i;
        y_q    <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
        // fold the angle into the right half plane
        if (angle_i > HALF_Z) begin
          z_q   <= angle_i - PI_Z;
          neg_q <= 1'b1;
        end else if (angle_i < -HALF_Z) begin
          z_q   <= angle_i + PI_Z;
          neg_q <= 1'b1;
        end else begin
          z_q   <= angle_i;
          neg_q <= 1'b0;
        end
      end else if (busy_q) begin
        if (!z_q[ZW-1]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? -x_q : x_q;
  assign sin_o  = neg_q ? -y_q : y_q;

endmodule

// File: hdl/bpu_div.sv
// Restoring unsigned divider, one quotient bit per cycle, with overflow detect.
// Depends on bpu_pkg for the divisor width.
module bpu_div import bpu_pkg::*; #(
  parameter int QW = FRAC_BITS_DEF + 7,
  parameter int NW = FRAC_BITS_DEF + 38
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic          ovf_o,
  output logic [QW-1:0] quo_o
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_q, den_q;
  logic [QW-1:0] low_q, quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q, ovf_q;
  logic [DW:0]   rs, rdiff;
  logic          take;

  assign rs    = {rem_q, low_q[QW-1]};
  assign rdiff = rs - {1'b0, den_q};
  assign take  = rs >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      low_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        den_q <= den_i;
        rem_q <= DW'(num_i[NW-1:QW]);
        low_q <= num_i[QW-1:0];
        quo_q <= '0;
        cnt_q <= '0;
        // quotient would not fit in QW bits
        if ({{(DW+QW-NW){1'b0}}, num_i} >= {den_i, {QW{1'b0}}}) begin
          ovf_q  <= 1'b1;
          done_q <= 1'b1;
        end else begin
          ovf_q  <= 1'b0;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q <= take ? rdiff[DW-1:0] : rs[DW-1:0];
        quo_q <= {quo_q[QW-2:0], take};
        low_q <= {low_q[QW-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quo_o  = quo_q;

endmodule

// File: hdl/bicycle_pose_update.sv
// Kinematic bicycle dead reckoning, top level and step sequencer.
// Depends on bpu_pkg, bpu_cordic, bpu_div and bicycle_pose_update_defines.svh.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries distance and steering angle.
//   Output channel (out_valid_o/out_ready_i) returns the new pose and a clip
//   flag, one result per request, in order.
//   Config port: cfg_we_i with cfg_idx_i/cfg_data_i writes wheelbase (0),
//   start x (1), start y (2) or start heading (3); a start write also loads
//   the current pose. Unknown indexes are ignored. Write only while idle.
// Timing:
//   One request at a time; in_ready_o is high only in the idle state.
//   Each request uses the shared CORDIC unit and the shared bit-serial divider
//   in turn: CORDIC tangent, tangent division, heading increment division,
//   then CORDIC sine/cosine. Steering at or beyond pi/2 skips the first
//   CORDIC pass and the first division.
// Reset: pose and heading clear to zero, wheelbase to 1.0, no result pending.
// Stall: a finished result holds on the outputs; a new request is accepted
//   meanwhile, and its result waits until the previous one is taken.
module bicycle_pose_update import bpu_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [31:0]    distance_i,
  input  logic signed [17:0]    steer_angle_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [31:0]    pos_x_out_o,
  output logic signed [31:0]    pos_y_out_o,
  output logic signed [18:0]    heading_out_o,
  output logic                  steer_clipped_o
);

`include "bicycle_pose_update_defines.svh"

  localparam int AS = 32 - FRAC_BITS;
  localparam int QW = FRAC_BITS + 7;
  localparam int NW = FRAC_BITS + 38;
  localparam int HW = (FRAC_BITS + 3 > 20) ? FRAC_BITS + 3 : 20;
  localparam int VW = HW + 2;
  localparam int TW = QW + 1;
  localparam int PW = 32 + XW;

  localparam longint PiQ     = (PI_Q32 + (longint'(1) <<< (31 - FRAC_BITS))) >>> AS;
  localparam longint HalfPiQ = (HALF_PI_Q32 + (longint'(1) <<< (31 - FRAC_BITS))) >>> AS;

  localparam logic signed [VW-1:0] PI_V     = VW'(PiQ);
  localparam logic signed [VW-1:0] TWO_PI_V = VW'(2 * PiQ);
  localparam logic [QW-1:0]        PI_M     = QW'(PiQ);
  localparam logic [QW-1:0]        TAN_LIM  = QW'(longint'(64) <<< FRAC_BITS);
  localparam logic signed [31:0]   HALF_S   = 32'(HalfPiQ);
  localparam logic [30:0]          ONE_WB   = 31'(longint'(1) <<< FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_TAN_GO, S_TAN_RUN, S_TDIV_GO, S_TDIV_RUN, S_MUL_T, S_IDIV_GO,
    S_IDIV_RUN, S_WRAP, S_ROT_GO, S_ROT_RUN, S_MUL_X, S_ADD_X, S_ADD_Y, S_EMIT
  } state_e;

  state_e               state_q;
  logic [30:0]          wheelbase_q;
  logic signed [31:0]   pos_x_q, pos_y_q, d_q;
  logic signed [17:0]   s_q;
  logic signed [HW-1:0] heading_q;
  logic [QW-1:0]        t_q;
  logic                 clip_q, psign_q;
  logic signed [VW-1:0] v_q;
  logic signed [PW-1:0] prod_q;
  logic                 out_valid_q, out_clip_q;
  logic signed [31:0]   out_x_q, out_y_q;
  logic signed [18:0]   out_h_q;

  // shared unit hookup
  logic                 cor_start, cor_done;
  logic signed [ZW-1:0] cor_angle;
  logic signed [XW-1:0] cor_seed, cor_cos, cor_sin;
  logic                 div_start, div_done, div_ovf;
  logic [NW-1:0]        div_num;
  logic [DW-1:0]        div_den;
  logic [QW-1:0]        div_quo;

  logic signed [63:0]   s_wide, h_wide;
  logic [XW-1:0]        sin_mag;
  logic [PW-1:0]        prod_mag;
  logic signed [TW-1:0] t_signed;
  logic signed [XW-1:0] mul_b;
  logic signed [PW-1:0] prod_d, prod_rnd;
  logic [QW-1:0]        inc_mag;
  logic                 inc_sat;
  logic signed [VW-1:0] inc_s;
  logic                 steer_wide;

  assign s_wide  = {{46{s_q[17]}}, s_q} <<< AS;
  assign h_wide  = {{(64-HW){heading_q[HW-1]}}, heading_q} <<< AS;

  assign cor_start = (state_q == S_TAN_GO) || (state_q == S_ROT_GO);
  assign cor_angle = (state_q == S_TAN_GO) ? s_wide[ZW-1:0] : h_wide[ZW-1:0];
  assign cor_seed  = (state_q == S_TAN_GO) ? XW'(UNIT30) : XW'(GAIN30);

  assign sin_mag  = cor_sin[XW-1] ? XW'(-cor_sin) : XW'(cor_sin);
  assign prod_mag = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);

  assign div_start = (state_q == S_TDIV_GO) || (state_q == S_IDIV_GO);
  always_comb begin
    if (state_q == S_TDIV_GO) begin
      div_num = NW'(sin_mag) << FRAC_BITS;
      div_den = DW'(cor_cos);
    end else begin
      div_num = prod_mag[NW-1:0];
      div_den = (wheelbase_q == '0) ? DW'(1) : DW'(wheelbase_q);
    end
  end

  assign t_signed = s_q[17] ? -TW'(t_q) : TW'(t_q);

  always_comb begin
    unique case (state_q)
      S_MUL_T: mul_b = XW'(t_signed);
      S_ADD_X: mul_b = cor_sin;
      default: mul_b = cor_cos;
    endcase
  end
  assign prod_d   = d_q * mul_b;
  assign prod_rnd = prod_q + PW'(longint'(1) <<< 29);

  assign inc_sat = div_ovf || (div_quo > PI_M);
  assign inc_mag = inc_sat ? PI_M : div_quo;
  assign inc_s   = psign_q ? -VW'(inc_mag) : VW'(inc_mag);

  assign steer_wide = (32'(steer_angle_i) >= HALF_S) || (32'(steer_angle_i) <= -HALF_S);

  bpu_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .seed_i  (cor_seed),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  bpu_div #(
    .QW(QW),
    .NW(NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .ovf_o   (div_ovf),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wheelbase_q <= ONE_WB;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      out_valid_q <= 1'b0;
      d_q         <= '0;
      s_q         <= '0;
      t_q         <= '0;
      clip_q      <= 1'b0;
      psign_q     <= 1'b0;
      v_q         <= '0;
      prod_q      <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_h_q     <= '0;
      out_clip_q  <= 1'b0;
    end else begin
      prod_q <= prod_d;
      // S_EMIT drives the valid flag itself
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WHEELBASE:     wheelbase_q <= cfg_data_i[30:0];
          REG_START_X:       pos_x_q     <= cfg_data_i;
          REG_START_Y:       pos_y_q     <= cfg_data_i;
          REG_START_HEADING: heading_q   <= HW'(signed'(cfg_data_i[18:0]));
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            d_q <= distance_i;
            s_q <= steer_angle_i;
            if (steer_wide) begin
              t_q     <= TAN_LIM;
              clip_q  <= 1'b1;
              state_q <= S_MUL_T;
            end else begin
              clip_q  <= 1'b0;
              state_q <= S_TAN_GO;
            end
          end
        end
        S_TAN_GO: state_q <= S_TAN_RUN;
        S_TAN_RUN: begin
          if (cor_done) begin
            if (cor_cos[XW-1] || cor_cos == '0) begin
              t_q     <= TAN_LIM;
              clip_q  <= 1'b1;
              state_q <= S_MUL_T;
            end else begin
              state_q <= S_TDIV_GO;
            end
          end
        end
        S_TDIV_GO: state_q <= S_TDIV_RUN;
        S_TDIV_RUN: begin
          if (div_done) begin
            if (div_ovf || div_quo > TAN_LIM) begin
              t_q    <= TAN_LIM;
              clip_q <= 1'b1;
            end else begin
              t_q <= div_quo;
            end
            state_q <= S_MUL_T;
          end
        end
        S_MUL_T: state_q <= S_IDIV_GO;
        S_IDIV_GO: begin
          psign_q <= prod_q[PW-1];
          state_q <= S_IDIV_RUN;
        end
        S_IDIV_RUN: begin
          if (div_done) begin
            if (inc_sat) begin
              clip_q <= 1'b1;
            end
            v_q     <= VW'(heading_q) + inc_s + PI_V;
            state_q <= S_WRAP;
          end
        end
        S_WRAP: begin
          // fold one turn at a time into [0, 2*pi)
          if (v_q[VW-1]) begin
            v_q <= v_q + TWO_PI_V;
          end else if (v_q >= TWO_PI_V) begin
            v_q <= v_q - TWO_PI_V;
          end else begin
            heading_q <= HW'(v_q - PI_V);
            state_q   <= S_ROT_GO;
          end
        end
        S_ROT_GO: state_q <= S_ROT_RUN;
        S_ROT_RUN: begin
          if (cor_done) begin
            state_q <= S_MUL_X;
          end
        end
        S_MUL_X: state_q <= S_ADD_X;
        S_ADD_X: begin
          pos_x_q <= pos_x_q + prod_rnd[61:30];
          state_q <= S_ADD_Y;
        end
        S_ADD_Y: begin
          pos_y_q <= pos_y_q + prod_rnd[61:30];
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the previous result is taken
          if (!out_valid_q || out_ready_i) begin
            out_x_q     <= pos_x_q;
            out_y_q     <= pos_y_q;
            out_h_q     <= heading_q[18:0];
            out_clip_q  <= clip_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign pos_x_out_o     = out_x_q;
  assign pos_y_out_o     = out_y_q;
  assign heading_out_o   = out_h_q;
  assign steer_clipped_o = out_clip_q;

  `BPU_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "ready after request")
  `BPU_ASSERT_IMPL(a_cor_done_state, cor_done, state_q == S_TAN_RUN || state_q == S_ROT_RUN, "stray CORDIC done")
  `BPU_ASSERT_IMPL(a_div_done_state, div_done, state_q == S_TDIV_RUN || state_q == S_IDIV_RUN, "stray divider done")
  `BPU_ASSERT_NEXT(a_emit_loads, state_q == S_EMIT && (!out_valid_o || out_ready_i), out_valid_o && in_ready_o, "result not emitted")

endmodule
